>>> hdl/dlbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlbc_pkg;

  localparam int WORD_W        = 32;
  localparam int CLASS_W       = 4;
  localparam int THR_W         = 17;
  localparam int BOX_W         = 8;
  localparam int FIELD_W       = 3;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = THR_W;
  localparam int THR_FRAC_BITS = 16;

  localparam int CLASS_COUNT_DEFAULT   = 9;
  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam logic [THR_W-1:0] THR_RESET       = 17'd42598;
  localparam logic [BOX_W-1:0] MAX_BOXES_RESET = 8'd200;

  // Position of the score word inside a five-word box
  localparam logic [FIELD_W-1:0] SCORE_FIELD = 3'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCORE_THRESHOLD = 1'b0,
    REG_MAX_BOXES       = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_COUNT = 3'b001,
    PH_BOX   = 3'b010,
    PH_STOP  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [THR_W-1:0] score_threshold;
    logic [BOX_W-1:0] max_boxes;
  } cfg_t;

  typedef struct packed {
    logic                      found;
    logic [CLASS_W-1:0]        best_class;
    logic signed [WORD_W-1:0]  peak_score;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/dlbc_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module dlbc_parse #(
  parameter int CLASS_COUNT   = dlbc_pkg::CLASS_COUNT_DEFAULT,
  parameter int FRACTION_BITS = dlbc_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 step,
  input  wire logic signed [dlbc_pkg::WORD_W-1:0]   word,
  input  wire logic                                 last_word,
  input  wire dlbc_pkg::cfg_t                       cfg,
  output dlbc_pkg::result_t                         res
);
  import dlbc_pkg::*;

  localparam int QW     = WORD_W - FRACTION_BITS + 1;
  localparam int CMP_W  = WORD_W + THR_FRAC_BITS + 2;
  localparam logic [FRACTION_BITS:0] IntTol =
    (FRACTION_BITS+1)'((1 << FRACTION_BITS) / 10000);
  localparam logic [FRACTION_BITS:0] OneFx = (FRACTION_BITS+1)'(1 << FRACTION_BITS);
  localparam logic [WORD_W-1:0] MinusOne = ~((32'd1 << FRACTION_BITS) - 32'd1);
  localparam logic [CLASS_W-1:0] ClassCountC = CLASS_W'(CLASS_COUNT);

  phase_t                     phase, phase_next;
  logic [CLASS_W-1:0]         class_index, class_index_next;
  logic [BOX_W-1:0]           boxes_left, boxes_left_next;
  logic [FIELD_W-1:0]         field_index, field_index_next;
  logic [CLASS_W-1:0]         best_class_reg, best_class_next;
  logic signed [WORD_W-1:0]   peak_score_reg, peak_score_next;
  logic                       found_reg, found_next;

  logic [FRACTION_BITS-1:0]   frac;
  logic [FRACTION_BITS:0]     frac_up;
  logic                       near_low, near_high, is_int;
  logic signed [QW-1:0]       q;
  logic                       q_le0, q_gt;
  logic [BOX_W-1:0]           cnt;
  logic [CLASS_W-1:0]         class_inc;
  phase_t                     phase_after_class;
  logic signed [CMP_W-1:0]    score_scaled, thr_scaled;
  logic                       score_ok;
  logic [BOX_W-1:0]           left_dec;

  // Count word: round to nearest integer within tolerance
  assign frac      = word[FRACTION_BITS-1:0];
  assign frac_up   = OneFx - {1'b0, frac};
  assign near_low  = {1'b0, frac} <= IntTol;
  assign near_high = frac_up <= IntTol;
  assign is_int    = near_low || near_high;
  assign q         = $signed({word[WORD_W-1], word[WORD_W-1:FRACTION_BITS]})
                     + $signed(QW'(!near_low));
  assign q_le0     = q[QW-1] || (q == '0);
  assign q_gt      = $unsigned(q) > QW'(cfg.max_boxes);
  assign cnt       = q_gt ? cfg.max_boxes : q[BOX_W-1:0];

  assign class_inc         = class_index + CLASS_W'(1);
  assign phase_after_class = (class_inc >= ClassCountC) ? PH_STOP : PH_COUNT;

  // Compare score * 2^16 against threshold * 2^F exactly
  assign score_scaled = $signed({{(CMP_W-WORD_W){word[WORD_W-1]}}, word}) <<< THR_FRAC_BITS;
  assign thr_scaled   = $signed({{(CMP_W-THR_W){1'b0}}, cfg.score_threshold})
                        <<< FRACTION_BITS;
  assign score_ok     = (score_scaled >= thr_scaled) && (word > peak_score_reg);
  assign left_dec     = boxes_left - BOX_W'(boxes_left != '0);

  always_comb begin
    phase_next       = phase;
    class_index_next = class_index;
    boxes_left_next  = boxes_left;
    field_index_next = field_index;
    best_class_next  = best_class_reg;
    peak_score_next  = peak_score_reg;
    found_next       = found_reg;
    unique case (phase)
      PH_COUNT: begin
        if (class_index >= ClassCountC || !is_int) begin
          phase_next = PH_STOP;
        end else if (q_le0 || cnt == '0) begin
          class_index_next = class_inc;
          field_index_next = '0;
          boxes_left_next  = '0;
          phase_next       = phase_after_class;
        end else begin
          boxes_left_next  = cnt;
          field_index_next = '0;
          phase_next       = PH_BOX;
        end
      end
      PH_BOX: begin
        if (field_index < SCORE_FIELD) begin
          field_index_next = field_index + FIELD_W'(1);
        end else begin
          if (score_ok) begin
            peak_score_next = word;
            best_class_next = class_index;
            found_next      = 1'b1;
          end
          field_index_next = '0;
          boxes_left_next  = left_dec;
          if (left_dec == '0) begin
            class_index_next = class_inc;
            phase_next       = phase_after_class;
          end
        end
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase
  end

  assign res.found      = found_next;
  assign res.best_class = found_next ? best_class_next : '0;
  assign res.peak_score = peak_score_next;

  always_ff @(posedge clk) begin
    if (rst || (step && last_word)) begin
      phase          <= PH_COUNT;
      class_index    <= '0;
      boxes_left     <= '0;
      field_index    <= '0;
      best_class_reg <= '0;
      peak_score_reg <= MinusOne;
      found_reg      <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      class_index    <= class_index_next;
      boxes_left     <= boxes_left_next;
      field_index    <= field_index_next;
      best_class_reg <= best_class_next;
      peak_score_reg <= peak_score_next;
      found_reg      <= found_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/detection_list_best_class.sv
`timescale 1ns / 1ps
`default_nettype none

// Best-detection finder for a per-class detector output list. Takes one signed
// fixed-point word per cycle (count word per class, then five words per box) and
// keeps the highest score at or above score_threshold with its class. A word with
// last_word set closes the frame: one result word (found, best_class, peak_score)
// follows and the frame state clears. Throughput is one word per cycle; a word
// is held in the input register, and the parse logic feeds the result register
// as the word steps on, so a result is registered when its last word leaves the
// input register. Input stalls only while the input register holds a last word
// and the previous result still waits, unaccepted, in the output register.
module detection_list_best_class #(
  parameter int CLASS_COUNT   = dlbc_pkg::CLASS_COUNT_DEFAULT,
  parameter int FRACTION_BITS = dlbc_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write_en,
  input  wire logic [dlbc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [dlbc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [dlbc_pkg::WORD_W-1:0]     word,
  input  wire logic                                   last_word,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        found,
  output logic [dlbc_pkg::CLASS_W-1:0]                best_class,
  output logic signed [dlbc_pkg::WORD_W-1:0]          peak_score
);
  import dlbc_pkg::*;

  cfg_t                     cfg;
  logic                     s1_valid;
  logic signed [WORD_W-1:0] s1_word;
  logic                     s1_last;
  logic                     step;
  result_t                  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.score_threshold <= THR_RESET;
      cfg.max_boxes       <= MAX_BOXES_RESET;
    end else if (cfg_write_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_SCORE_THRESHOLD: cfg.score_threshold <= cfg_data;
        REG_MAX_BOXES:       cfg.max_boxes       <= cfg_data[BOX_W-1:0];
      endcase
    end
  end

  // Advance the held word unless it closes a frame and the result slot is busy
  assign step     = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= word;
      s1_last <= last_word;
    end
  end

  dlbc_parse #(
    .CLASS_COUNT   (CLASS_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .word      (s1_word),
    .last_word (s1_last),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last) begin
      found      <= res.found;
      best_class <= res.best_class;
      peak_score <= res.peak_score;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dlbc_pkg::*;

  // Tracks the best box of the frame in flight and holds the frame results still due.
  class best_box_tracker;
    localparam int NUM_CLS = CLASS_COUNT_DEFAULT;
    localparam int FRAC    = FRACTION_BITS_DEFAULT;
    localparam int INT_TOL = (1 << FRAC) / 10000;

    logic [THR_W-1:0]         thr;
    logic [BOX_W-1:0]         box_cap;
    phase_t                   ph;
    logic [CLASS_W-1:0]       cls_idx;
    logic [BOX_W-1:0]         boxes_left;
    logic [FIELD_W-1:0]       field_idx;
    logic [CLASS_W-1:0]       lead_cls;
    logic signed [WORD_W-1:0] best_sc;
    logic                     found_r;
    result_t                  results_due[$];
    int                       mismatches;

    function new();
      thr = THR_RESET;
      box_cap = MAX_BOXES_RESET;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      ph = PH_COUNT;
      cls_idx = '0;
      boxes_left = '0;
      field_idx = '0;
      lead_cls = '0;
      best_sc = -(32'sd1 <<< FRAC);
      found_r = 1'b0;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SCORE_THRESHOLD: thr = v[THR_W-1:0];
        REG_MAX_BOXES:       box_cap = v[BOX_W-1:0];
        default: ;
      endcase
    endfunction

    function void advance_class();
      cls_idx = cls_idx + 1'b1;
      field_idx = '0;
      boxes_left = '0;
      ph = (int'(cls_idx) >= NUM_CLS) ? PH_STOP : PH_COUNT;
    endfunction

    function void parse_count(logic signed [WORD_W-1:0] w);
      logic [FRAC-1:0] frac;
      longint q;
      longint cnt;
      frac = w[FRAC-1:0];
      if (int'(cls_idx) >= NUM_CLS) begin
        ph = PH_STOP;
        return;
      end
      // not within tolerance of an integer: stop the frame
      if (frac > INT_TOL && ((longint'(1) << FRAC) - longint'(frac)) > INT_TOL) begin
        ph = PH_STOP;
        return;
      end
      q = (longint'(w) - longint'(frac)) / (longint'(1) << FRAC);
      if (frac > INT_TOL) q = q + 1;
      if (q <= 0) begin
        advance_class();
        return;
      end
      cnt = (q > longint'(box_cap)) ? longint'(box_cap) : q;
      if (cnt == 0) begin
        advance_class();
        return;
      end
      boxes_left = cnt[BOX_W-1:0];
      field_idx = '0;
      ph = PH_BOX;
    endfunction

    function void parse_box_word(logic signed [WORD_W-1:0] w);
      if (field_idx < SCORE_FIELD) begin
        field_idx = field_idx + 1'b1;
        return;
      end
      // scale both sides to a common fraction width; ties keep the earlier box
      if ((longint'(w) <<< THR_FRAC_BITS) >= (longint'(thr) <<< FRAC) && w > best_sc) begin
        best_sc = w;
        lead_cls = cls_idx;
        found_r = 1'b1;
      end
      field_idx = '0;
      if (boxes_left > 0) boxes_left = boxes_left - 1'b1;
      if (boxes_left == 0) advance_class();
    endfunction

    function void take_word(logic signed [WORD_W-1:0] w, logic last);
      result_t r;
      case (ph)
        PH_COUNT: parse_count(w);
        PH_BOX:   parse_box_word(w);
        default: ;
      endcase
      if (last) begin
        r.found = found_r;
        r.best_class = found_r ? lead_cls : '0;
        r.peak_score = best_sc;
        results_due.push_back(r);
        clear_frame();
      end
    endfunction

    function void note_mismatch(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s): found/class/score want %0b/%0d/%h, got %0b/%0d/%h",
                 what, want.found, want.best_class, want.peak_score,
                 got.found, got.best_class, got.peak_score);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        want = '0;
        note_mismatch("no result due", want, got);
        return;
      end
      want = results_due.pop_front();
      if (got.found !== want.found || got.best_class !== want.best_class ||
          got.peak_score !== want.peak_score)
        note_mismatch("field", want, got);
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 8;
  localparam int NUM_PHASES  = 6;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [WORD_W-1:0]   word = '0;
  logic                       last_word = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       found;
  logic [CLASS_W-1:0]         best_class;
  logic signed [WORD_W-1:0]   peak_score;

  best_box_tracker          tracker;
  logic signed [WORD_W-1:0] frame_words[$];
  logic [THR_W-1:0]         cur_thr = THR_RESET;
  int                       cur_max = int'(MAX_BOXES_RESET);
  logic signed [WORD_W-1:0] last_score = '0;
  int                       items_sent = 0;
  int                       frames_sent = 0;
  int                       snd_mode = 0;
  int                       rcv_mode = 0;
  bit                       hold_req = 1'b0;
  int                       stall_cycles = 0;

  detection_list_best_class dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .word         (word),
    .last_word    (last_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .best_class   (best_class),
    .peak_score   (peak_score)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (snd_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input logic signed [WORD_W-1:0] w, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    word <= w;
    last_word <= last;
    do @(posedge clk); while (!in_ready);
    tracker.take_word(w, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_words.size(); i++)
      send_word(frame_words[i], i == frame_words.size() - 1);
    items_sent += frame_words.size();
    frames_sent++;
  endtask

  // hold the input low until every frame result is out, then let the pipe settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_regs(input logic [THR_W-1:0] thr, input int max_b);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_SCORE_THRESHOLD;
    cfg_data <= CFG_DATA_W'(thr);
    tracker.set_reg(REG_SCORE_THRESHOLD, CFG_DATA_W'(thr));
    @(posedge clk);
    cfg_index <= REG_MAX_BOXES;
    cfg_data <= CFG_DATA_W'(max_b);
    tracker.set_reg(REG_MAX_BOXES, CFG_DATA_W'(max_b));
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_thr = thr;
    cur_max = max_b;
  endtask

  function automatic logic signed [WORD_W-1:0] pick_score();
    logic signed [WORD_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = $signed({15'd0, cur_thr});
      1: s = $signed({15'd0, cur_thr}) - 1;
      2: s = $signed({15'd0, cur_thr}) + 1;
      3: s = last_score;
      4: s = $urandom;
      5: s = $urandom_range(0, 65536);
      6: s = 32'sh7FFF_FFFF;
      7: s = 32'sh8000_0000;
      default: s = $signed({15'd0, cur_thr}) + $urandom_range(0, 20000);
    endcase
    last_score = s;
    return s;
  endfunction

  function automatic int clamp_boxes(longint q);
    if (q <= 0) return 0;
    return (q > cur_max) ? cur_max : int'(q);
  endfunction

  function automatic void build_frame(int cap);
    int n;
    longint q;
    logic signed [WORD_W-1:0] w;
    frame_words.delete();
    for (int c = 0; c < CLASS_COUNT_DEFAULT; c++) begin
      if (frame_words.size() >= cap) return;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: q = 0;
        4: q = -longint'($urandom_range(1, 5));
        5: q = -32768;
        6, 7, 8, 9, 10, 11, 12: q = 1;
        13, 14, 15: q = 2;
        16: q = 3;
        17: q = ($urandom_range(0, 1) == 0) ? longint'(cur_max + 1) : $urandom_range(256, 32767);
        18: begin
          // off-integer count: stop parsing, the rest is ignored
          w = $signed({14'd0, 2'($urandom_range(0, 3)), 16'($urandom_range(7, 65529))});
          frame_words.push_back(w);
          repeat ($urandom_range(0, 3)) frame_words.push_back($urandom);
          return;
        end
        default: begin
          q = $urandom_range(0, 2);
          w = WORD_W'(q <<< 16) + $signed($urandom_range(0, 12)) - 6;
          frame_words.push_back(w);
          n = clamp_boxes(q);
          for (int b = 0; b < n && frame_words.size() < cap; b++) begin
            repeat (4) frame_words.push_back($urandom);
            frame_words.push_back(pick_score());
          end
          continue;
        end
      endcase
      frame_words.push_back(WORD_W'(q <<< 16));
      n = clamp_boxes(q);
      for (int b = 0; b < n && frame_words.size() < cap; b++) begin
        repeat (4) frame_words.push_back($urandom);
        frame_words.push_back(pick_score());
      end
    end
    // trailing words after all classes are ignored
    repeat ($urandom_range(0, 3)) frame_words.push_back($urandom);
  endfunction

  function automatic void build_random_frame();
    int r;
    int keep;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      frame_words.delete();
      repeat ($urandom_range(1, 8)) frame_words.push_back($urandom);
    end else begin
      build_frame($urandom_range(0, 3) == 0 ? 60 : 35);
      if (r == 1) begin
        keep = $urandom_range(1, frame_words.size());
        while (frame_words.size() > keep) void'(frame_words.pop_back());
      end
    end
    if (frame_words.size() == 0) frame_words.push_back($urandom);
  endfunction

  task automatic send_directed();
    // score equal to threshold, skipped classes, near-integer count, tie, off-integer stop
    frame_words = '{32'sh0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                    32'shFFFF_FFFF, 32'sh0000_A666, 32'sh0000_0000, 32'shFFFE_0000,
                    32'sh0000_FFFA, 32'sh1234_5678, 32'shEDCB_A987, 32'sh5555_5555,
                    32'shAAAA_AAAA, 32'sh0000_A666, 32'sh0001_8000, 32'sh7FFF_FFFF};
    send_frame();
    // best score one below threshold: nothing found
    frame_words = '{32'sh0001_0005, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh3333_3333,
                    32'shCCCC_CCCC, 32'sh0000_A665};
    send_frame();
    frame_words = '{32'sh8000_0000};
    send_frame();
    // frame closes mid-box
    frame_words = '{32'sh0003_0000, 32'sh0001_0000, 32'sh7FFF_0000};
    send_frame();
  endtask

  task automatic pressure_burst();
    snd_mode = 0;
    hold_req = 1'b1;
    repeat (12) begin
      frame_words = '{32'sh0001_0000};
      repeat (4) frame_words.push_back($urandom);
      frame_words.push_back(pick_score());
      send_frame();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result('{found: found, best_class: best_class, peak_score: peak_score});
  end

  initial begin
    int stall_left;
    int r;
    int cyc;
    stall_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        case (rcv_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= (r < 70);
          default: begin
            out_ready <= (r < 40);
            if (r > 96) stall_left = $urandom_range(10, 40);
          end
        endcase
      end
      cyc++;
      if (cyc % 150 == 0) rcv_mode = $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL detection_list_best_class");
      $finish;
    end
  end

  initial begin
    logic [THR_W-1:0] thr_set[NUM_PHASES];
    int               max_set[NUM_PHASES];
    int               start_items;
    int               start_frames;
    tracker = new();
    thr_set = '{THR_RESET, 17'd0, 17'd65536, 17'd32768, 17'd0, 17'd0};
    max_set = '{int'(MAX_BOXES_RESET), 255, 1, 0, 0, 0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p >= 4) begin
        thr_set[p] = THR_W'($urandom_range(0, 65536));
        max_set[p] = $urandom_range(0, 8);
      end
      write_regs(thr_set[p], max_set[p]);
      if (p == 0) begin
        send_directed();
        wait_drain();
      end
      if (p == 1) begin
        pressure_burst();
        wait_drain();
      end
      start_items = items_sent;
      start_frames = frames_sent;
      while (items_sent - start_items < 220 || frames_sent - start_frames < 8) begin
        snd_mode = $urandom_range(0, 2);
        build_random_frame();
        send_frame();
      end
      wait_drain();
    end
    while (items_sent < 1300 || frames_sent < 48) begin
      snd_mode = $urandom_range(0, 2);
      build_random_frame();
      send_frame();
    end
    wait_drain();
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("PASS detection_list_best_class");
    else
      $display("FAIL detection_list_best_class");
    $finish;
  end
endmodule
